### rtl/spimst_pkg.sv
// ----------------------------------------------------------------------------
// spimst_pkg
// Shared constants and types for the three-wire SPI master sequencer.
// ----------------------------------------------------------------------------
package spimst_pkg;

    // Longest transfer in bits; command bits at or above this are dropped.
    localparam int MAX_BITS = 32;
    localparam int IDX_W    = $clog2(MAX_BITS);
    localparam int DIFF_W   = IDX_W + 1;

    // Transfer length field as it arrives on the stream.
    localparam int LEN_W  = 5;
    localparam int CMD_W  = 32;
    localparam int RECV_W = 32;
    localparam int PIN_W  = 6;

    // Bits driven on the data line before it is handed to the slave.
    localparam logic [DIFF_W-1:0] TRI_AFTER = DIFF_W'(8);
    localparam logic [LEN_W-1:0]  LEN_CAP   = LEN_W'(MAX_BITS - 1);

    // Stream payload layouts.
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    // Low nibble of the pin word: enable, select, clock, MOSI.
    localparam logic [3:0] WORD_TRI    = 4'h7;
    localparam logic [3:0] WORD_IDLE   = 4'hf;
    localparam logic [3:0] WORD_ACTIVE = 4'hb;
    localparam logic [3:0] WORD_LOW    = 4'h8;
    localparam logic [3:0] WORD_HIGH   = 4'ha;

    typedef struct packed {
        logic [PIN_W-1:0]  pin_word;
        logic              busy;
        logic              done;
        logic [RECV_W-1:0] received;
    } t_result;

endpackage

### rtl/spimst_core.sv
// ----------------------------------------------------------------------------
// spimst_core
// Sequencer state and the per-tick pin word; state advances on each step.
// ----------------------------------------------------------------------------
module spimst_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_three_wire,
    input  logic                       i_step,
    input  logic                       i_start,
    input  logic [spimst_pkg::CMD_W-1:0] i_cmd,
    input  logic [spimst_pkg::LEN_W-1:0] i_len,
    input  logic                       i_miso,
    output spimst_pkg::t_result        o_result
);
    import spimst_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PRE_IDLE,
        PH_PRE_ACTIVE,
        PH_CLK_LOW,
        PH_CLK_HIGH,
        PH_END_IDLE,
        PH_END_TRI
    } t_phase;

    t_phase              r_phase,  n_phase;
    logic [IDX_W-1:0]    r_bit,    n_bit;
    logic [IDX_W-1:0]    r_top,    n_top;
    logic [MAX_BITS-1:0] r_tx,     n_tx;
    logic [MAX_BITS-1:0] r_rx,     n_rx;
    logic                r_rd,     n_rd;
    logic                r_tri,    n_tri;

    logic [DIFF_W-1:0]   sent;
    logic                tx_bit;
    logic [3:0]          word;
    logic                busy;
    logic                done;
    logic [IDX_W-1:0]    start_top;

    assign sent      = {1'b0, r_top} - {1'b0, r_bit};
    assign tx_bit    = r_tx[r_bit];
    assign start_top = (i_len > LEN_CAP) ? LEN_CAP[IDX_W-1:0] : i_len[IDX_W-1:0];

    always_comb begin
        n_phase = r_phase;
        n_bit   = r_bit;
        n_top   = r_top;
        n_tx    = r_tx;
        n_rx    = r_rx;
        n_rd    = r_rd;
        n_tri   = r_tri;
        word    = WORD_TRI;
        busy    = 1'b1;
        done    = 1'b0;
        unique case (r_phase)
            PH_PRE_IDLE: begin
                word    = WORD_IDLE;
                n_phase = PH_PRE_ACTIVE;
            end
            PH_PRE_ACTIVE: begin
                word    = WORD_ACTIVE;
                n_phase = PH_CLK_LOW;
            end
            PH_CLK_LOW: begin
                // In three-wire mode, release the data line once the first eight bits are out.
                n_tri   = i_three_wire && (sent >= TRI_AFTER);
                word    = WORD_LOW | {3'b000, tx_bit};
                n_phase = PH_CLK_HIGH;
            end
            PH_CLK_HIGH: begin
                word = WORD_HIGH | {3'b000, tx_bit};
                n_rx = {r_rx[MAX_BITS-2:0], i_miso};
                if (r_bit == '0) begin
                    n_phase = PH_END_IDLE;
                end else begin
                    n_bit   = r_bit - 1'b1;
                    n_phase = PH_CLK_LOW;
                end
            end
            PH_END_IDLE: begin
                word    = WORD_IDLE;
                n_phase = PH_END_TRI;
            end
            PH_END_TRI: begin
                n_rd    = 1'b0;
                n_tri   = 1'b0;
                done    = 1'b1;
                n_phase = PH_IDLE;
            end
            default: begin
                busy    = 1'b0;
                n_phase = PH_IDLE;
                if (i_start) begin
                    n_top   = start_top;
                    n_bit   = start_top;
                    n_tx    = i_cmd[MAX_BITS-1:0];
                    n_rx    = '0;
                    n_rd    = i_cmd[start_top];
                    n_tri   = 1'b0;
                    busy    = 1'b1;
                    n_phase = PH_PRE_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        o_result.pin_word = {n_rd, n_tri, word};
        o_result.busy     = busy;
        o_result.done     = done;
        o_result.received = done ? RECV_W'(r_rx) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_bit   <= '0;
            r_top   <= '0;
            r_tx    <= '0;
            r_rx    <= '0;
            r_rd    <= 1'b0;
            r_tri   <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_bit   <= n_bit;
            r_top   <= n_top;
            r_tx    <= n_tx;
            r_rx    <= n_rx;
            r_rd    <= n_rd;
            r_tri   <= n_tri;
        end
    end

`ifndef SYNTHESIS
    a_bit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit <= r_top)
        else $error("bit position above top index");

    a_bit_countdown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_phase == PH_CLK_HIGH && r_bit != '0
        |=> r_phase == PH_CLK_LOW && r_bit == $past(r_bit) - 1'b1)
        else $error("bit countdown skipped");

    a_done_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.done |-> o_result.busy && o_result.pin_word == {2'b00, WORD_TRI})
        else $error("closing word malformed");

    a_recv_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_result.done |-> o_result.received == '0)
        else $error("received word leaked before done");
`endif

endmodule

### rtl/spi_master_three_wire_sequencer.sv
// ----------------------------------------------------------------------------
// spi_master_three_wire_sequencer
// Mode 3 SPI master sequencer: one beat in, one pin word out, per tick.
// ----------------------------------------------------------------------------
//  channel   | direction | fields (low bit up)
//  ----------+-----------+----------------------------------------------------
//  s_axis    | in        | tdata: command_word, length_minus_one, miso;
//            |           | tuser: start_req
//  m_axis    | out       | tdata: pin_word, busy_res, received_word;
//            |           | tlast: done_res
//  cfg       | in        | i_cfg_wr_data: three_wire_mode
//
//  Each accepted input beat yields exactly one output beat, registered and shown in the next cycle.
//  A new beat is taken every cycle while the output register is empty or
//  being drained, so sustained rate is one beat per clock.
//  The sequencer state advances only on accepted beats; stalls on either side
//  freeze it. A transfer of N bits spans 2*N + 5 beats including the start.
//  Reset (i_rst_n low, synchronous) returns the sequencer to idle and empties
//  the output register; three_wire_mode resets to 0.
// ----------------------------------------------------------------------------
module spi_master_three_wire_sequencer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config: three_wire_mode
    input  logic                                i_cfg_wr_en,
    input  logic                                i_cfg_wr_data,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [31:0] command_word, [36:32] length_minus_one, [37] miso, [39:38] zero
    input  logic [spimst_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [0] start_req
    input  logic                                s_axis_tuser,
    // output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [5:0] pin_word, [6] busy_res, [38:7] received_word, [39] zero
    output logic [spimst_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // done_res
    output logic                                m_axis_tlast
);
    import spimst_pkg::*;

    logic                   r_three_wire;
    logic                   r_out_valid;
    t_result                r_out;
    t_result                step_result;
    logic                   accept;

    // Take a beat whenever the output slot is free or leaving this cycle.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    spimst_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_three_wire (r_three_wire),
        .i_step       (accept),
        .i_start      (s_axis_tuser),
        .i_cmd        (s_axis_tdata[CMD_W-1:0]),
        .i_len        (s_axis_tdata[CMD_W+LEN_W-1:CMD_W]),
        .i_miso       (s_axis_tdata[CMD_W+LEN_W]),
        .o_result     (step_result)
    );

    // Hold the config bit; it is read live at each clock-low word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_three_wire <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_three_wire <= i_cfg_wr_data;
        end
    end

    // Output register: load on accept, drop once taken downstream.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= step_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out.done;
    assign m_axis_tdata  = OUT_TDATA_W'({r_out.received, r_out.busy, r_out.pin_word});

endmodule
